// File: src/bfg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery fuel gauge package
// Beat types, register codes and curve constants shared by the gauge and
// its checker.
// ----------------------------------------------------------------------------
package bfg_pkg;

  localparam int unsigned SmpW = 16;
  localparam int unsigned PctW = 7;
  localparam int unsigned CntW = 6;
  localparam int unsigned IdxW = 3;
  localparam int unsigned DifW = 9;
  localparam int unsigned MulW = 20;
  localparam int unsigned PrdW = DifW + MulW;

  typedef struct packed {
    logic            ac_present;
    logic [SmpW-1:0] voltage_sample;
  } bfg_in_t;

  typedef struct packed {
    logic [PctW-1:0] charge_percent;
    logic            low_battery;
    logic            battery_alarm;
  } bfg_out_t;

  typedef enum logic [IdxW-1:0] {
    REG_CHG_ONE    = 3'd0,
    REG_CHG_TW_ONE = 3'd1,
    REG_CHG_EI_ONE = 3'd2,
    REG_CHG_FULL   = 3'd3,
    REG_DIS_FULL   = 3'd4,
    REG_DIS_NN     = 3'd5,
    REG_DIS_ONE    = 3'd6
  } bfg_reg_e;

  localparam logic [SmpW-1:0] ChgOneRst   = 16'd0;
  localparam logic [SmpW-1:0] ChgTwOneRst = 16'd0;
  localparam logic [SmpW-1:0] ChgEiOneRst = 16'd0;
  localparam logic [SmpW-1:0] ChgFullRst  = 16'hFFFF;
  localparam logic [SmpW-1:0] DisFullRst  = 16'hFFFF;
  localparam logic [SmpW-1:0] DisNnRst    = 16'hFFFF;
  localparam logic [SmpW-1:0] DisOneRst   = 16'd0;

  // curve steps at 100x scale and segment lengths
  localparam int unsigned StepA = 750;
  localparam int unsigned StepB = 166;
  localparam int unsigned StepC = 368;
  localparam int unsigned StepD = 303;
  localparam int unsigned SegA  = 20;
  localparam int unsigned SegB  = 60;
  localparam int unsigned SegC  = 19;
  localparam int unsigned SegD  = 99;

  // a segment matches while the raw difference stays below these
  localparam logic [SmpW-1:0] LimA = SmpW'((StepA * SegA + 99) / 100);
  localparam logic [SmpW-1:0] LimB = SmpW'((StepB * SegB + 99) / 100);
  localparam logic [SmpW-1:0] LimC = SmpW'((StepC * SegC + 99) / 100);
  localparam logic [SmpW-1:0] LimD = SmpW'((StepD * SegD + 99) / 100);

  // reciprocals: floor(100*d/step) == (d * Rcp) >> MulW for d < 2**DifW
  localparam int unsigned Scale = 100 * (2 ** MulW);
  localparam logic [MulW-1:0] RcpA = MulW'((Scale + StepA - 1) / StepA);
  localparam logic [MulW-1:0] RcpB = MulW'((Scale + StepB - 1) / StepB);
  localparam logic [MulW-1:0] RcpC = MulW'((Scale + StepC - 1) / StepC);
  localparam logic [MulW-1:0] RcpD = MulW'((Scale + StepD - 1) / StepD);

  localparam logic [CntW-1:0] SettleAc  = 6'd1;
  localparam logic [CntW-1:0] SettleBat = 6'd50;
  localparam logic [CntW-1:0] CntMax    = 6'd63;

  localparam logic [PctW-1:0] PctZero = 7'd0;
  localparam logic [PctW-1:0] PctLow  = 7'd20;
  localparam logic [PctW-1:0] PctBaseB = 7'd21;
  localparam logic [PctW-1:0] PctBaseC = 7'd81;
  localparam logic [PctW-1:0] PctTopD = 7'd99;
  localparam logic [PctW-1:0] PctFull = 7'd100;

endpackage

// File: src/battery_fuel_gauge_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery fuel gauge unit
// Takes one beat per cycle: an AC flag and a converter sample. A changed
// sample is taken after one tick on AC or fifty consecutive changed ticks on
// battery, then mapped through the charge or discharge curve to a percentage
// with low-battery and latched alarm flags. Each beat yields one result beat
// in the next cycle; a new beat is accepted every cycle while the output
// register is empty or being drained. The curve mapping is a single
// combinational pass with four constant reciprocal multipliers.
// Configuration writes are taken at any edge with cfg_we_i high; an index
// past the last register is ignored.
// ----------------------------------------------------------------------------
module battery_fuel_gauge_unit (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [bfg_pkg::IdxW-1:0] cfg_idx_i,
  input  logic [bfg_pkg::SmpW-1:0] cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  bfg_pkg::bfg_in_t        in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output bfg_pkg::bfg_out_t       out_data_o
);
  import bfg_pkg::*;

  logic [SmpW-1:0] chg_one_q, chg_tw_one_q, chg_ei_one_q, chg_full_q;
  logic [SmpW-1:0] dis_full_q, dis_nn_q, dis_one_q;

  logic [SmpW-1:0] acc_q, acc_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [PctW-1:0] pct_q, pct_d;
  logic            alarm_q, alarm_d;
  logic            out_valid_q;
  bfg_out_t        out_q, out_d;

  logic [SmpW-1:0] smp;
  logic            ac;
  logic            differ;
  logic            accept;
  logic [CntW-1:0] cnt_inc;
  logic [CntW-1:0] limit;
  logic [SmpW-1:0] dif_a, dif_b, dif_c, dif_d;
  logic [PrdW-1:0] prd_a, prd_b, prd_c, prd_d;
  logic [PctW-1:0] q_a, q_b, q_c, q_d;
  logic [PctW-1:0] map_pct;
  logic            map_hit;
  logic            low;
  logic            take;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign take        = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chg_one_q    <= ChgOneRst;
      chg_tw_one_q <= ChgTwOneRst;
      chg_ei_one_q <= ChgEiOneRst;
      chg_full_q   <= ChgFullRst;
      dis_full_q   <= DisFullRst;
      dis_nn_q     <= DisNnRst;
      dis_one_q    <= DisOneRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CHG_ONE:    chg_one_q    <= cfg_data_i;
        REG_CHG_TW_ONE: chg_tw_one_q <= cfg_data_i;
        REG_CHG_EI_ONE: chg_ei_one_q <= cfg_data_i;
        REG_CHG_FULL:   chg_full_q   <= cfg_data_i;
        REG_DIS_FULL:   dis_full_q   <= cfg_data_i;
        REG_DIS_NN:     dis_nn_q     <= cfg_data_i;
        REG_DIS_ONE:    dis_one_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    smp     = in_data_i.voltage_sample;
    ac      = in_data_i.ac_present;
    differ  = smp != acc_q;
    cnt_inc = (cnt_q == CntMax) ? cnt_q : cnt_q + 1'b1;
    limit   = ac ? SettleAc : SettleBat;
    accept  = differ && (cnt_inc >= limit);

    dif_a = smp - chg_one_q;
    dif_b = smp - chg_tw_one_q;
    dif_c = smp - chg_ei_one_q;
    dif_d = dis_nn_q - smp;
    prd_a = dif_a[DifW-1:0] * RcpA;
    prd_b = dif_b[DifW-1:0] * RcpB;
    prd_c = dif_c[DifW-1:0] * RcpC;
    prd_d = dif_d[DifW-1:0] * RcpD;
    q_a   = prd_a[MulW+PctW-1:MulW];
    q_b   = prd_b[MulW+PctW-1:MulW];
    q_c   = prd_c[MulW+PctW-1:MulW];
    q_d   = prd_d[MulW+PctW-1:MulW];

    map_pct = PctZero;
    map_hit = 1'b1;
    if (ac) begin
      if (smp < chg_one_q) begin
        map_pct = PctZero;
      end else if (smp < chg_tw_one_q) begin
        map_hit = dif_a < LimA;
        map_pct = q_a + 1'b1;
      end else if (smp < chg_ei_one_q) begin
        map_hit = dif_b < LimB;
        map_pct = PctBaseB + q_b;
      end else if (smp < chg_full_q) begin
        map_hit = dif_c < LimC;
        map_pct = PctBaseC + q_c;
      end else begin
        map_pct = PctFull;
      end
    end else begin
      if (smp >= dis_full_q) begin
        map_pct = PctFull;
      end else if (smp >= dis_one_q) begin
        if (smp > dis_nn_q) begin
          map_pct = PctTopD;
        end else begin
          map_hit = dif_d < LimD;
          map_pct = PctTopD - q_d;
        end
      end else begin
        map_pct = PctZero;
      end
    end

    pct_d = (accept && map_hit) ? map_pct : pct_q;
    acc_d = accept ? smp : acc_q;
    cnt_d = (!differ || accept) ? '0 : cnt_inc;

    if (ac) begin
      low     = 1'b0;
      alarm_d = alarm_q;
    end else begin
      low     = pct_d <= PctLow;
      alarm_d = low;
    end

    out_d.charge_percent = pct_d;
    out_d.low_battery    = low;
    out_d.battery_alarm  = alarm_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      cnt_q       <= '0;
      pct_q       <= '0;
      alarm_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        acc_q   <= acc_d;
        cnt_q   <= cnt_d;
        pct_q   <= pct_d;
        alarm_q <= alarm_d;
      end
      if (in_ready_o) begin
        out_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= out_d;
    end
  end

endmodule

// File: src/bfg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery fuel gauge checker
// Port-level assertions on the gauge, bound to the gauge module.
// ----------------------------------------------------------------------------
module bfg_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input bfg_pkg::bfg_out_t        out_data_o
);
  import bfg_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat dropped or changed while stalled");

  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted beat gave no result beat");

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.charge_percent <= PctFull)
    else $error("charge percent above full");

  a_low_alarm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.low_battery |->
      out_data_o.battery_alarm && (out_data_o.charge_percent <= PctLow))
    else $error("low battery without alarm or above low level");

endmodule

bind battery_fuel_gauge_unit bfg_checker u_bfg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// File: test/battery_fuel_gauge_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery fuel gauge unit testbench
// Drives AC flag and sample beats through the valid/ready input, mirrors the
// settle counter, both curves and the alarm latch in a local gauge model, and
// checks every output beat in order. A short directed table runs under reset
// register values. Then several register settings follow: typical curves, all
// zero, all ones and scrambled thresholds. Each carries battery settle runs,
// AC updates and noise; all but the last add random stalls on both sides, and
// two of them add a long output hold-off.
// ----------------------------------------------------------------------------
module battery_fuel_gauge_unit_tb;
  import bfg_pkg::*;

  localparam int unsigned CentScale   = 100;
  localparam int unsigned RegCount    = 7;
  localparam logic [IdxW-1:0] RegSpare = 3'd7;
  localparam int unsigned HoldCycles  = 64;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned RandomBeats = 1300;
  localparam int unsigned CycleLimit  = 200000;

  typedef enum {SET_TYPICAL, SET_ZERO, SET_MAX, SET_SCRAMBLED} setting_e;

  typedef struct {
    bit              ac;
    logic [SmpW-1:0] smp;
    int unsigned     reps;
    bit              typed;
    bfg_out_t        want;
  } probe_row_t;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we;
  logic [IdxW-1:0] cfg_idx;
  logic [SmpW-1:0] cfg_data;
  logic            in_valid;
  logic            in_ready;
  bfg_in_t         in_data;
  logic            out_valid;
  logic            out_ready;
  bfg_out_t        out_data;

  int unsigned     holds_asked;
  int unsigned     idle_odds;

  logic [SmpW-1:0] gauge_regs [RegCount];
  logic [SmpW-1:0] held_sample;
  logic [CntW-1:0] settle_cnt;
  logic [PctW-1:0] pct_now;
  logic            alarm_now;
  bfg_out_t        expected_readings [$];

  int unsigned beats_sent;
  int unsigned readings_seen;
  int unsigned mismatches;
  int unsigned ac_updates;
  int unsigned bat_updates;
  int unsigned low_reads;
  int unsigned settings_run;
  int unsigned holds_done;

  probe_row_t probe_rows [13] = '{
    '{1'b0, 16'h0000,  1, 1'b1, '{PctZero, 1'b1, 1'b1}},
    '{1'b1, 16'h0000,  1, 1'b1, '{PctZero, 1'b0, 1'b1}},
    '{1'b1, 16'h0001,  1, 1'b0, '0},
    '{1'b1, 16'h0000,  1, 1'b0, '0},
    '{1'b1, 16'hFFFF,  1, 1'b1, '{PctFull, 1'b0, 1'b1}},
    '{1'b1, 16'hFFFE,  1, 1'b1, '{PctFull, 1'b0, 1'b1}},
    '{1'b0, 16'hFFFE,  1, 1'b1, '{PctFull, 1'b0, 1'b0}},
    '{1'b0, 16'h0000, 10, 1'b0, '0},
    '{1'b0, 16'hFFFE,  1, 1'b0, '0},
    '{1'b0, 16'h5555,  1, 1'b0, '0},
    '{1'b1, 16'h5555,  1, 1'b0, '0},
    '{1'b0, 16'hAAAA, 50, 1'b0, '0},
    '{1'b1, 16'h0000,  1, 1'b0, '0}
  };

  battery_fuel_gauge_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int unsigned rise_index(input int unsigned v, input int unsigned base,
                                             input int unsigned step, input int unsigned n);
    int unsigned i;
    if (v < base) return 1;
    i = (CentScale * (v - base)) / step + 1;
    return (i <= n) ? i : 0;
  endfunction

  function automatic bfg_out_t predict_reading(input bfg_in_t beat);
    int unsigned v;
    int unsigned i;
    bfg_out_t    rd;
    v = beat.voltage_sample;
    if (v != held_sample) begin
      if (settle_cnt < CntMax) settle_cnt++;
      if (settle_cnt >= (beat.ac_present ? SettleAc : SettleBat)) begin
        held_sample = beat.voltage_sample;
        if (beat.ac_present) begin
          ac_updates++;
          if (v < gauge_regs[REG_CHG_ONE]) begin
            pct_now = PctZero;
          end else if (v < gauge_regs[REG_CHG_TW_ONE]) begin
            i = rise_index(v, gauge_regs[REG_CHG_ONE], StepA, SegA);
            if (i != 0) pct_now = PctW'(i);
          end else if (v < gauge_regs[REG_CHG_EI_ONE]) begin
            i = rise_index(v, gauge_regs[REG_CHG_TW_ONE], StepB, SegB);
            if (i != 0) pct_now = PctW'(PctLow + i);
          end else if (v < gauge_regs[REG_CHG_FULL]) begin
            i = rise_index(v, gauge_regs[REG_CHG_EI_ONE], StepC, SegC);
            if (i != 0) pct_now = PctW'(PctBaseC - 1 + i);
          end else begin
            pct_now = PctFull;
          end
        end else begin
          bat_updates++;
          if (v >= gauge_regs[REG_DIS_FULL]) begin
            pct_now = PctFull;
          end else if (v >= gauge_regs[REG_DIS_ONE]) begin
            i = (v > gauge_regs[REG_DIS_NN]) ? 1 :
                (CentScale * (gauge_regs[REG_DIS_NN] - v)) / StepD + 1;
            if (i <= SegD) pct_now = PctW'(PctFull - i);
          end else begin
            pct_now = PctZero;
          end
        end
      end
    end
    if (v == held_sample) settle_cnt = '0;

    rd.charge_percent = pct_now;
    if (beat.ac_present) begin
      rd.low_battery = 1'b0;
    end else if (pct_now <= PctLow) begin
      rd.low_battery = 1'b1;
      alarm_now = 1'b1;
    end else begin
      rd.low_battery = 1'b0;
      alarm_now = 1'b0;
    end
    rd.battery_alarm = alarm_now;
    if (rd.low_battery) low_reads++;
    return rd;
  endfunction

  function automatic logic [SmpW-1:0] pick_sample(input bit ac);
    int unsigned roll;
    int unsigned lo;
    int unsigned hi;
    roll = $urandom_range(19, 0);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    if (roll < 4) return SmpW'($urandom_range(65535, 0));
    lo = 65535;
    hi = 0;
    for (int k = 0; k < RegCount; k++) begin
      if ((k <= int'(REG_CHG_FULL)) == ac) begin
        if (gauge_regs[k] < lo) lo = gauge_regs[k];
        if (gauge_regs[k] > hi) hi = gauge_regs[k];
      end
    end
    lo = (lo > 40) ? lo - 40 : 0;
    hi = (hi + 40 > 65535) ? 65535 : hi + 40;
    return SmpW'($urandom_range(hi, lo));
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 40) $display("MISMATCH at reading %0d: %s", readings_seen, what);
  endtask

  task automatic send_beat(input bfg_in_t beat, input bit typed, input bfg_out_t want);
    bfg_out_t rd;
    if (idle_odds != 0 && $urandom_range(idle_odds, 1) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(negedge clk_i); while (!in_ready);
    rd = predict_reading(beat);
    expected_readings.push_back(typed ? want : rd);
    beats_sent++;
    @(posedge clk_i);
  endtask

  task automatic drain_pipeline();
    in_valid <= 1'b0;
    do @(negedge clk_i); while (expected_readings.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [SmpW-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    if (idx < RegCount) gauge_regs[idx] = val;
  endtask

  task automatic apply_setting(input setting_e s);
    logic [SmpW-1:0] vals [RegCount];
    int unsigned     base;
    case (s)
      SET_ZERO: begin
        foreach (vals[k]) vals[k] = '0;
      end
      SET_MAX: begin
        foreach (vals[k]) vals[k] = '1;
      end
      SET_SCRAMBLED: begin
        foreach (vals[k]) vals[k] = SmpW'($urandom_range(65535, 0));
      end
      default: begin
        base = $urandom_range(60000, 0);
        vals[REG_CHG_ONE]    = SmpW'(base);
        vals[REG_CHG_TW_ONE] = vals[REG_CHG_ONE] + SmpW'($urandom_range(170, 0));
        vals[REG_CHG_EI_ONE] = vals[REG_CHG_TW_ONE] + SmpW'($urandom_range(120, 0));
        vals[REG_CHG_FULL]   = vals[REG_CHG_EI_ONE] + SmpW'($urandom_range(90, 0));
        base = $urandom_range(60000, 0);
        vals[REG_DIS_ONE]    = SmpW'(base);
        vals[REG_DIS_NN]     = vals[REG_DIS_ONE] + SmpW'($urandom_range(330, 0));
        vals[REG_DIS_FULL]   = vals[REG_DIS_NN] + SmpW'($urandom_range(30, 0));
      end
    endcase
    for (int k = 0; k < RegCount; k++) write_reg(IdxW'(k), vals[k]);
    write_reg(RegSpare, SmpW'($urandom_range(65535, 0)));
    cfg_we <= 1'b0;
    @(posedge clk_i);
    settings_run++;
  endtask

  task automatic random_burst();
    int unsigned kind;
    int unsigned len;
    bfg_in_t     beat;
    kind = $urandom_range(19, 0);
    if (kind < 12) begin
      len = $urandom_range(60, 45);
      beat.ac_present = 1'b0;
      repeat (len) begin
        beat.voltage_sample = pick_sample(1'b0);
        if ($urandom_range(39, 0) == 0) beat.voltage_sample = held_sample;
        else if (beat.voltage_sample == held_sample)
          beat.voltage_sample = beat.voltage_sample ^ 16'd1;
        send_beat(beat, 1'b0, '0);
      end
    end else if (kind < 17) begin
      len = $urandom_range(8, 1);
      beat.ac_present = 1'b1;
      beat.voltage_sample = pick_sample(1'b1);
      repeat (len) begin
        if ($urandom_range(3, 0) != 0) beat.voltage_sample = pick_sample(1'b1);
        send_beat(beat, 1'b0, '0);
      end
    end else begin
      len = $urandom_range(4, 1);
      repeat (len) begin
        beat = bfg_in_t'($urandom);
        send_beat(beat, 1'b0, '0);
      end
    end
  endtask

  always @(negedge clk_i) begin : check_readings
    bfg_out_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (expected_readings.size() == 0) begin
        report_mismatch($sformatf("unexpected beat, percent %0d", out_data.charge_percent));
      end else begin
        want = expected_readings.pop_front();
        if (out_data.charge_percent !== want.charge_percent)
          report_mismatch($sformatf("charge_percent got %0d want %0d",
                                    out_data.charge_percent, want.charge_percent));
        if (out_data.low_battery !== want.low_battery)
          report_mismatch($sformatf("low_battery got %b want %b",
                                    out_data.low_battery, want.low_battery));
        if (out_data.battery_alarm !== want.battery_alarm)
          report_mismatch($sformatf("battery_alarm got %b want %b",
                                    out_data.battery_alarm, want.battery_alarm));
      end
      readings_seen++;
    end
  end

  initial begin : receiver
    out_ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (holds_done < holds_asked) begin
        out_ready <= 1'b0;
        repeat (HoldCycles - 1) @(posedge clk_i);
        holds_done++;
      end else if (idle_odds != 0 && $urandom_range(idle_odds, 1) == 1) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(6, 1) - 1) @(posedge clk_i);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    repeat (CycleLimit) @(posedge clk_i);
    $display("Timeout with %0d readings still owed", expected_readings.size());
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    static setting_e plan [7] = '{SET_TYPICAL, SET_ZERO, SET_TYPICAL, SET_MAX,
                                  SET_SCRAMBLED, SET_TYPICAL, SET_TYPICAL};
    bfg_in_t     beat;
    int unsigned start;
    cfg_we   <= 1'b0;
    cfg_idx  <= '0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_data  <= '0;
    holds_asked = 0;
    idle_odds = 4;
    gauge_regs[REG_CHG_ONE]    = ChgOneRst;
    gauge_regs[REG_CHG_TW_ONE] = ChgTwOneRst;
    gauge_regs[REG_CHG_EI_ONE] = ChgEiOneRst;
    gauge_regs[REG_CHG_FULL]   = ChgFullRst;
    gauge_regs[REG_DIS_FULL]   = DisFullRst;
    gauge_regs[REG_DIS_NN]     = DisNnRst;
    gauge_regs[REG_DIS_ONE]    = DisOneRst;
    held_sample = '0;
    settle_cnt  = '0;
    pct_now     = PctZero;
    alarm_now   = 1'b0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (probe_rows[r]) begin
      beat.ac_present     = probe_rows[r].ac;
      beat.voltage_sample = probe_rows[r].smp;
      repeat (probe_rows[r].reps) send_beat(beat, probe_rows[r].typed, probe_rows[r].want);
    end
    drain_pipeline();

    start = beats_sent;
    foreach (plan[p]) begin
      apply_setting(plan[p]);
      idle_odds = (p == $size(plan) - 1) ? 0 : $urandom_range(10, 3);
      if (p == 1 || p == 4) holds_asked++;
      while (beats_sent < start + RandomBeats * (p + 1) / $size(plan)) random_burst();
      drain_pipeline();
    end

    $display("Covered %0d readings (%0d low) over %0d register settings plus reset values",
             readings_seen, low_reads, settings_run);
    $display("Curve updates: %0d on AC, %0d on battery; %0d long output hold-offs",
             ac_updates, bat_updates, holds_done);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/bfg_pkg.sv
src/battery_fuel_gauge_unit.sv
src/bfg_checker.sv
test/battery_fuel_gauge_unit_tb.sv
